/* hw/rtl/zmw_pkg.sv */
`timescale 1ns / 1ps
package zmw_pkg;

  // Window geometry
  localparam int MAX_SAMPLES  = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int ADDR_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int CFG_W        = 3;
  localparam int CH_W         = $clog2(MAX_CHANNELS + 1);

  // Field widths
  localparam int SMP_W   = 16;
  localparam int Z_W     = 16;
  localparam int DISP_W  = 11;
  localparam int SCORE_W = 32;

  // Datapath widths
  localparam int SUM_W   = SMP_W + ADDR_W;
  localparam int MEAN_W  = SMP_W + 5;
  localparam int DEV_W   = SMP_W + 6;
  localparam int SQ_W    = 2 * DEV_W;
  localparam int ACC_W   = 2 * DEV_W - 2 + ADDR_W;
  localparam int ESUM_W  = 2 * Z_W + ADDR_W;
  localparam int PROD_W  = ESUM_W + CNT_W;
  localparam int DIV_W   = (ACC_W > PROD_W) ? ACC_W : PROD_W;
  localparam int ROOT_W  = (ACC_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int DSR_W   = ROOT_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int SQ_CNT_W  = $clog2(ROOT_W);

  // Stream payload widths
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 80;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CH_INIT,
    ST_SUM,
    ST_MEAN,
    ST_MEAN_W,
    ST_SSQ,
    ST_VAR,
    ST_VAR_W,
    ST_SQRT,
    ST_SQRT_W,
    ST_Z_ISSUE,
    ST_Z_READ,
    ST_Z_DIV,
    ST_Z_WAIT,
    ST_NEXT_CH,
    ST_SCORE_INIT,
    ST_SCORE,
    ST_MUL,
    ST_SDIV,
    ST_SDIV_W,
    ST_OUT
  } state_e;

endpackage

/* hw/rtl/zmw_div.sv */
`timescale 1ns / 1ps
module zmw_div import zmw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DSR_W-1:0]     rem_q, dsr_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DSR_W:0]       shifted, diff;
  logic                 ge;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = shifted >= {1'b0, dsr_q};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hw/rtl/zmw_isqrt.sv */
`timescale 1ns / 1ps
module zmw_isqrt import zmw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  logic                busy_q, done_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W:0]     rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+2:0]   cur, trial, diff;
  logic                ge;

  // One digit: bring down two radicand bits, try root*4+1
  always_comb begin
    cur   = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial = {1'b0, root_q, 2'b01};
    diff  = cur - trial;
    ge    = cur >= trial;
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SQ_CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and root
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

/* hw/rtl/zero_mean_window_ssd_match_core.sv */
`timescale 1ns / 1ps
// Zero-mean, unit-variance windowed SSD matching cost with running minimum.
// Input stream: one sample pair of both windows per request; tlast closes the
// window, tuser carries the missing flags and the end-of-range flag.
// Config: cfg_we_i writes the channel count (0 acts as 1, above the maximum
// acts as the maximum); write it only while the block is idle.
// A request that does not close a window is only stored. A closing request
// starts a sequence over the stored windows, per window and channel: a sum
// pass, a mean division, a squared deviation pass, a variance division and
// a square root, then one division per present sample unless the standard
// deviation is zero. A score pass follows, with one more division if any
// sample pair was valid. All divisions run on the shared one-bit-per-cycle
// divider (DIV_W = 53). tready stays low during that sequence. Output
// stream: one result per closing request, held in an output register; the
// block takes new samples while the result waits. A stall on the output
// holds the next window's result, with tready low, until the register is
// free. Reset clears the fill count and the running minimum; window stores
// need no clearing.
module zero_mean_window_ssd_match_core import zmw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [15:0] sample_a, [31:16] sample_b, [42:32] disp_index, [47:43] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] a_missing, [1] b_missing, [2] last_disp
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  // output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [31:0] window_score, [42:32] best_disp, [74:43] best_score, [79:75] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]   chan_cfg_q;
  logic [CH_W-1:0]    ch_q, ch_eff, c_q;
  logic               w_q;
  logic [CNT_W-1:0]   fill_q, fill_next, n_q, i_q, k_q, stride;
  logic [DISP_W-1:0]  disp_q, best_disp_q;
  logic               last_disp_q;
  logic [SCORE_W-1:0] best_score_q, score_q;

  logic signed [SUM_W-1:0]  s_q;
  logic signed [MEAN_W-1:0] m_q;
  logic [ACC_W-1:0]         acc_q, var_q;
  logic [ROOT_W-1:0]        sd_q;
  logic signed [DEV_W-1:0]  dev_q, dev1;
  logic                     zmiss_q;
  logic [PROD_W-1:0]        prod_q;

  logic              v1_q, v2_q, v3_q, ok2_q, ok3_q, ok1;
  logic [SQ_W-1:0]   sq_q;
  logic signed [SQ_W-1:0] sq_s;

  logic [SMP_W:0]    wa_q, wb_q, x_sel;
  logic [Z_W-1:0]    na_q, nb_q, z_sat, nrm_wdata;
  logic [SMP_W:0]    win_a [MAX_SAMPLES];
  logic [SMP_W:0]    win_b [MAX_SAMPLES];
  logic [Z_W-1:0]    nrm_a [MAX_SAMPLES];
  logic [Z_W-1:0]    nrm_b [MAX_SAMPLES];

  logic in_acc, win_we, rd_en, nrm_we, in_stream, issue, pipe_empty, stream_done;
  logic out_load, cand;
  logic [SUM_W-1:0]   mag_s;
  logic [DEV_W-1:0]   abs_d;
  logic [DIV_W:0]     rnd;
  logic [SCORE_W-1:0] score_sat, new_best;
  logic [DISP_W-1:0]  new_disp;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  zmw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  zmw_isqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // Input handshake and fill
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign win_we    = in_acc && (fill_q < CNT_W'(MAX_SAMPLES));
  assign fill_next = fill_q + CNT_W'(win_we);

  // Clamp the channel count
  always_comb begin
    if (chan_cfg_q == '0) begin
      ch_eff = CH_W'(1);
    end else if (CH_W'(chan_cfg_q) > CH_W'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CH_W'(chan_cfg_q);
    end
  end

  // Streaming pass control
  assign in_stream   = (state_q == ST_SUM) || (state_q == ST_SSQ) || (state_q == ST_SCORE);
  assign issue       = in_stream && (i_q < n_q);
  assign stride      = (state_q == ST_SCORE) ? CNT_W'(1) : CNT_W'(ch_q);
  assign pipe_empty  = !v1_q && !v2_q && !v3_q;
  assign stream_done = in_stream && !issue && pipe_empty;

  // Stage one operands from the read registers
  always_comb begin
    x_sel = w_q ? wb_q : wa_q;
    if (state_q == ST_SCORE) begin
      ok1  = !wa_q[SMP_W] && !wb_q[SMP_W];
      dev1 = DEV_W'(signed'(na_q)) - DEV_W'(signed'(nb_q));
    end else begin
      ok1  = !x_sel[SMP_W];
      dev1 = DEV_W'(signed'({x_sel[SMP_W-1:0], 4'b0000})) - DEV_W'(m_q);
    end
  end

  assign sq_s = dev_q * dev_q;

  // Division operands and start
  always_comb begin
    mag_s = s_q[SUM_W-1] ? SUM_W'(-s_q) : SUM_W'(s_q);
    abs_d = dev_q[DEV_W-1] ? DEV_W'(-dev_q) : DEV_W'(dev_q);
    div_req.start    = (state_q == ST_MEAN) || (state_q == ST_VAR) || (state_q == ST_SDIV) ||
                       (state_q == ST_Z_DIV && !zmiss_q && sd_q != '0);
    div_req.dividend = DIV_W'(acc_q);
    div_req.divisor  = DSR_W'(k_q);
    case (state_q)
      ST_MEAN:  div_req.dividend = DIV_W'({mag_s, 4'b0000}) + DIV_W'(k_q >> 1);
      ST_Z_DIV: begin
        div_req.dividend = DIV_W'({abs_d, 12'b0}) + DIV_W'(sd_q >> 1);
        div_req.divisor  = sd_q;
      end
      ST_SDIV:  div_req.dividend = DIV_W'(prod_q);
      default:  div_req.dividend = DIV_W'(acc_q);
    endcase
  end

  // Saturate the normalized value to Q4.12
  always_comb begin
    if (dev_q[DEV_W-1]) begin
      z_sat = (div_rsp.quotient > DIV_W'(32768)) ? 16'h8000
                                                 : Z_W'(-div_rsp.quotient[Z_W-1:0]);
    end else begin
      z_sat = (div_rsp.quotient > DIV_W'(32767)) ? 16'h7FFF : div_rsp.quotient[Z_W-1:0];
    end
  end

  // Round the score to Q16.16 and saturate
  always_comb begin
    rnd = {1'b0, div_rsp.quotient} + (DIV_W + 1)'(128);
    score_sat = (|rnd[DIV_W:SCORE_W+8]) ? '1 : rnd[SCORE_W+7:8];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_acc && s_axis_tlast_i) state_d = ST_CH_INIT;
      ST_CH_INIT:    state_d = ST_SUM;
      ST_SUM:        if (stream_done) state_d = (k_q == '0) ? ST_NEXT_CH : ST_MEAN;
      ST_MEAN:       state_d = ST_MEAN_W;
      ST_MEAN_W:     if (div_rsp.done) state_d = ST_SSQ;
      ST_SSQ:        if (stream_done) state_d = ST_VAR;
      ST_VAR:        state_d = ST_VAR_W;
      ST_VAR_W:      if (div_rsp.done) state_d = ST_SQRT;
      ST_SQRT:       state_d = ST_SQRT_W;
      ST_SQRT_W:     if (sqrt_rsp.done) state_d = ST_Z_ISSUE;
      ST_Z_ISSUE:    state_d = (i_q < n_q) ? ST_Z_READ : ST_NEXT_CH;
      ST_Z_READ:     state_d = ST_Z_DIV;
      ST_Z_DIV:      state_d = (zmiss_q || sd_q == '0) ? ST_Z_ISSUE : ST_Z_WAIT;
      ST_Z_WAIT:     if (div_rsp.done) state_d = ST_Z_ISSUE;
      ST_NEXT_CH: begin
        if (({1'b0, c_q} + 1'b1) < {1'b0, ch_q} || !w_q) state_d = ST_CH_INIT;
        else state_d = ST_SCORE_INIT;
      end
      ST_SCORE_INIT: state_d = ST_SCORE;
      ST_SCORE:      if (stream_done) state_d = (k_q == '0) ? ST_OUT : ST_MUL;
      ST_MUL:        state_d = ST_SDIV;
      ST_SDIV:       state_d = ST_SDIV_W;
      ST_SDIV_W:     if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:        if (out_load) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    rd_en          = issue || (state_q == ST_Z_ISSUE && i_q < n_q);
    sqrt_req.start = (state_q == ST_SQRT);
    sqrt_req.radicand = RAD_W'(var_q);
    nrm_we    = (state_q == ST_Z_DIV && !zmiss_q && sd_q == '0) ||
                (state_q == ST_Z_WAIT && div_rsp.done);
    nrm_wdata = (state_q == ST_Z_WAIT) ? z_sat : '0;
    out_load  = (state_q == ST_OUT) && (!m_axis_tvalid_o || m_axis_tready_i);
  end

  // Running minimum candidate
  always_comb begin
    cand     = score_q < best_score_q;
    new_best = cand ? score_q : best_score_q;
    new_disp = cand ? disp_q : best_disp_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      chan_cfg_q      <= CFG_W'(1);
      fill_q          <= '0;
      best_score_q    <= '1;
      best_disp_q     <= '0;
      m_axis_tvalid_o <= 1'b0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      v3_q            <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) chan_cfg_q <= cfg_wdata_i;
      if (in_acc) fill_q <= s_axis_tlast_i ? '0 : fill_next;
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (out_load) begin
        m_axis_tvalid_o <= 1'b1;
        best_score_q    <= last_disp_q ? '1 : new_best;
        best_disp_q     <= last_disp_q ? '0 : new_disp;
      end else if (m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast_i) begin
      n_q         <= fill_next;
      disp_q      <= s_axis_tdata_i[42:32];
      last_disp_q <= s_axis_tuser_i[2];
      ch_q        <= ch_eff;
      c_q         <= '0;
      w_q         <= 1'b0;
    end

    // address walk
    if (issue) i_q <= i_q + stride;
    case (state_q)
      ST_CH_INIT: begin
        i_q <= CNT_W'(c_q);
        s_q <= '0;
        k_q <= '0;
      end
      ST_MEAN_W: if (div_rsp.done) begin
        m_q   <= s_q[SUM_W-1] ? -MEAN_W'(div_rsp.quotient[MEAN_W-1:0])
                              : MEAN_W'(div_rsp.quotient[MEAN_W-1:0]);
        i_q   <= CNT_W'(c_q);
        acc_q <= '0;
      end
      ST_VAR_W:   if (div_rsp.done) var_q <= div_rsp.quotient[ACC_W-1:0];
      ST_SQRT_W: if (sqrt_rsp.done) begin
        sd_q <= sqrt_rsp.root;
        i_q  <= CNT_W'(c_q);
      end
      ST_Z_DIV:  if (zmiss_q || sd_q == '0) i_q <= i_q + CNT_W'(ch_q);
      ST_Z_WAIT: if (div_rsp.done) i_q <= i_q + CNT_W'(ch_q);
      ST_NEXT_CH: begin
        if (({1'b0, c_q} + 1'b1) < {1'b0, ch_q}) begin
          c_q <= c_q + 1'b1;
        end else begin
          c_q <= '0;
          w_q <= 1'b1;
        end
      end
      ST_SCORE_INIT: begin
        i_q   <= '0;
        acc_q <= '0;
        k_q   <= '0;
      end
      ST_SCORE:  if (stream_done && k_q == '0) score_q <= '0;
      ST_MUL:    prod_q <= acc_q[ESUM_W-1:0] * n_q;
      ST_SDIV_W: if (div_rsp.done) score_q <= score_sat;
      default: ;
    endcase

    // stage two: deviation or difference, sample sum
    if (v1_q || state_q == ST_Z_READ) dev_q <= dev1;
    if (state_q == ST_Z_READ) zmiss_q <= x_sel[SMP_W];
    ok2_q <= ok1;
    if (state_q == ST_SUM && v1_q && ok1) begin
      s_q <= s_q + SUM_W'(signed'(x_sel[SMP_W-1:0]));
      k_q <= k_q + 1'b1;
    end

    // stage three: square, then accumulate
    sq_q  <= unsigned'(sq_s);
    ok3_q <= ok2_q;
    if (v3_q && ok3_q && (state_q == ST_SSQ || state_q == ST_SCORE)) begin
      acc_q <= acc_q + ACC_W'(sq_q);
      if (state_q == ST_SCORE) k_q <= k_q + 1'b1;
    end

    // output register
    if (out_load) begin
      m_axis_tdata_o <= {5'b0, new_best, new_disp, score_q};
      m_axis_tlast_o <= last_disp_q;
    end
  end

  // Window stores
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_a[fill_q[ADDR_W-1:0]] <= {s_axis_tuser_i[0], s_axis_tdata_i[15:0]};
      win_b[fill_q[ADDR_W-1:0]] <= {s_axis_tuser_i[1], s_axis_tdata_i[31:16]};
    end
    if (rd_en) begin
      wa_q <= win_a[i_q[ADDR_W-1:0]];
      wb_q <= win_b[i_q[ADDR_W-1:0]];
    end
  end

  // Normalized value stores
  always_ff @(posedge clk_i) begin
    if (nrm_we && !w_q) nrm_a[i_q[ADDR_W-1:0]] <= nrm_wdata;
    if (nrm_we && w_q)  nrm_b[i_q[ADDR_W-1:0]] <= nrm_wdata;
    if (rd_en) begin
      na_q <= nrm_a[i_q[ADDR_W-1:0]];
      nb_q <= nrm_b[i_q[ADDR_W-1:0]];
    end
  end

  // Checks
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_best_le_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[74:43] <= m_axis_tdata_o[31:0]))
    else $error("best score above window score");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_SAMPLES))
    else $error("fill count beyond window depth");

  a_pipe_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> in_stream)
    else $error("read pipeline busy outside a streaming pass");

endmodule
